FILE: sv/mvs_pkg.sv
package mvs_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = 33;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = $clog2(FQ_DEPTH);

  localparam logic [7:0] MP_NIL      = 8'hc0;
  localparam logic [7:0] MP_FALSE    = 8'hc2;
  localparam logic [7:0] MP_TRUE     = 8'hc3;
  localparam logic [7:0] MP_BIN8     = 8'hc4;
  localparam logic [7:0] MP_BIN16    = 8'hc5;
  localparam logic [7:0] MP_BIN32    = 8'hc6;
  localparam logic [7:0] MP_FLOAT32  = 8'hca;
  localparam logic [7:0] MP_FLOAT64  = 8'hcb;
  localparam logic [7:0] MP_UINT8    = 8'hcc;
  localparam logic [7:0] MP_UINT16   = 8'hcd;
  localparam logic [7:0] MP_UINT32   = 8'hce;
  localparam logic [7:0] MP_UINT64   = 8'hcf;
  localparam logic [7:0] MP_INT8     = 8'hd0;
  localparam logic [7:0] MP_INT16    = 8'hd1;
  localparam logic [7:0] MP_INT32    = 8'hd2;
  localparam logic [7:0] MP_INT64    = 8'hd3;
  localparam logic [7:0] MP_STR8     = 8'hd9;
  localparam logic [7:0] MP_STR16    = 8'hda;
  localparam logic [7:0] MP_STR32    = 8'hdb;
  localparam logic [7:0] MP_ARRAY16  = 8'hdc;
  localparam logic [7:0] MP_ARRAY32  = 8'hdd;
  localparam logic [7:0] MP_MAP16    = 8'hde;
  localparam logic [7:0] MP_MAP32    = 8'hdf;
  localparam logic [7:0] MP_FIXMAP   = 8'h80;
  localparam logic [7:0] MP_FIXARRAY = 8'h90;
  localparam logic [7:0] MP_FIXSTR   = 8'ha0;
  localparam logic [7:0] MP_NEGFIX   = 8'he0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_DEEP    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    HK_BLOB  = 2'd0,
    HK_ARRAY = 2'd1,
    HK_MAP   = 2'd2
  } hkind_t;

  typedef enum logic [2:0] {
    TC_SCALAR,
    TC_PAYLOAD,
    TC_OPEN,
    TC_HEADER,
    TC_UNKNOWN
  } tcls_t;

  typedef struct packed {
    tcls_t      cls;
    logic [4:0] len;
    hkind_t     kind;
    logic [2:0] hbytes;
  } tdec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    tdec_t      dec;
  } fq_item_t;

  typedef struct packed {
    logic     valid;
    fq_item_t item;
  } fq_head_t;

  function automatic tdec_t decode_type(input logic [7:0] b);
    tdec_t d;
    d.cls    = TC_UNKNOWN;
    d.len    = 5'd0;
    d.kind   = HK_BLOB;
    d.hbytes = 3'd0;
    if (b < MP_FIXMAP || b >= MP_NEGFIX || b == MP_NIL || b == MP_FALSE || b == MP_TRUE) begin
      d.cls = TC_SCALAR;
    end else if ((b & 8'he0) == MP_FIXSTR) begin
      d.cls = TC_PAYLOAD;
      d.len = b[4:0];
    end else if ((b & 8'hf0) == MP_FIXMAP) begin
      d.cls = TC_OPEN;
      d.len = {b[3:0], 1'b0};
    end else if ((b & 8'hf0) == MP_FIXARRAY) begin
      d.cls = TC_OPEN;
      d.len = {1'b0, b[3:0]};
    end else begin
      case (b)
        MP_UINT8, MP_INT8: begin
          d.cls = TC_PAYLOAD;
          d.len = 5'd1;
        end
        MP_UINT16, MP_INT16: begin
          d.cls = TC_PAYLOAD;
          d.len = 5'd2;
        end
        MP_FLOAT32, MP_UINT32, MP_INT32: begin
          d.cls = TC_PAYLOAD;
          d.len = 5'd4;
        end
        MP_FLOAT64, MP_UINT64, MP_INT64: begin
          d.cls = TC_PAYLOAD;
          d.len = 5'd8;
        end
        MP_BIN8, MP_STR8: begin
          d.cls    = TC_HEADER;
          d.hbytes = 3'd1;
        end
        MP_BIN16, MP_STR16: begin
          d.cls    = TC_HEADER;
          d.hbytes = 3'd2;
        end
        MP_BIN32, MP_STR32: begin
          d.cls    = TC_HEADER;
          d.hbytes = 3'd4;
        end
        MP_ARRAY16: begin
          d.cls    = TC_HEADER;
          d.kind   = HK_ARRAY;
          d.hbytes = 3'd2;
        end
        MP_ARRAY32: begin
          d.cls    = TC_HEADER;
          d.kind   = HK_ARRAY;
          d.hbytes = 3'd4;
        end
        MP_MAP16: begin
          d.cls    = TC_HEADER;
          d.kind   = HK_MAP;
          d.hbytes = 3'd2;
        end
        MP_MAP32: begin
          d.cls    = TC_HEADER;
          d.kind   = HK_MAP;
          d.hbytes = 3'd4;
        end
        default: begin
          d.cls = TC_UNKNOWN;
        end
      endcase
    end
    return d;
  endfunction

endpackage

FILE: sv/mvs_front.sv
module mvs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_buffer,
  output mvs_pkg::fq_head_t head,
  input  logic              deq
);
  import mvs_pkg::*;

  fq_item_t             q_r [FQ_DEPTH];
  logic [FQ_AW-1:0]     wr_r, wr_nxt;
  logic [FQ_AW-1:0]     rd_r, rd_nxt;
  logic [FQ_AW:0]       cnt_r, cnt_nxt;
  logic                 enq;
  logic                 do_deq;
  fq_item_t             new_item;

  assign full     = (cnt_r == (FQ_AW+1)'(FQ_DEPTH));
  assign enq      = push && !full;
  assign do_deq   = deq && (cnt_r != '0);

  assign new_item.data = in_data_byte;
  assign new_item.eob  = in_end_of_buffer;
  assign new_item.dec  = decode_type(in_data_byte);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_r];

  always_comb begin
    wr_nxt  = enq ? wr_r + FQ_AW'(1) : wr_r;
    rd_nxt  = do_deq ? rd_r + FQ_AW'(1) : rd_r;
    cnt_nxt = cnt_r + (FQ_AW+1)'(enq) - (FQ_AW+1)'(do_deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_r] <= new_item;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FQ_AW+1)'(FQ_DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == (FQ_AW+1)'(FQ_DEPTH)) |-> (wr_r == rd_r))
    else $error("queue pointers disagree with count");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (enq && !do_deq) |=> (cnt_r == $past(cnt_r) + (FQ_AW+1)'(1)))
    else $error("queue count did not advance");
`endif

endmodule

FILE: sv/mvs_back.sv
module mvs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mvs_pkg::fq_head_t head,
  output logic              deq,
  output logic              empty,
  input  logic              pop,
  output logic [31:0]       out_value_size,
  output logic [1:0]        out_status
);
  import mvs_pkg::*;

  typedef enum logic [1:0] {
    S_TYPE,
    S_HEADER,
    S_PAYLOAD,
    S_UNWIND
  } state_t;

  typedef enum logic [1:0] {
    G_PEND,
    G_DONE,
    G_UNK,
    G_DEEP
  } go_t;

  state_t            state_r, state_nxt;
  logic [2:0]        hdr_left_r, hdr_left_nxt;
  logic [31:0]       acc_r, acc_nxt;
  hkind_t            kind_r, kind_nxt;
  logic [31:0]       pay_r, pay_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic              drop_r, drop_nxt;
  logic              eob_hold_r, eob_hold_nxt;
  logic [CNT_W-1:0]  stk_r [MAX_DEPTH];

  logic              ov_r, ov_nxt;
  logic [31:0]       osize_r, osize_nxt;
  status_t           ostat_r, ostat_nxt;

  logic              out_free;
  logic              take;
  logic              step;
  logic [LVL_W-1:0]  lvl_m1;
  logic [CNT_W-1:0]  top;
  logic [CNT_W-1:0]  top_dec;
  go_t               ed_go;
  logic              ed_more;
  logic [LVL_W-1:0]  ed_lvl;
  logic              ed_we;

  logic              stk_we;
  logic [IDX_W-1:0]  stk_idx;
  logic [CNT_W-1:0]  stk_wdata;

  go_t               go;
  logic              more;
  logic              fin;
  logic              fin_eob;
  logic              use_ed;
  logic              use_open;
  logic [CNT_W-1:0]  open_cnt;
  logic [31:0]       acc_sh;
  logic [2:0]        hl_dec;
  logic [31:0]       pl_dec;
  logic [31:0]       size_inc;
  fq_item_t          it;

  assign it       = head.item;
  assign out_free = !ov_r || pop;
  assign take     = head.valid && out_free && (state_r != S_UNWIND);
  assign step     = out_free && (state_r == S_UNWIND);
  assign deq      = take;

  // one unwind step on the open container at the top of the stack
  assign lvl_m1  = level_r - LVL_W'(1);
  assign top     = stk_r[lvl_m1[IDX_W-1:0]];
  assign top_dec = (top != '0) ? top - CNT_W'(1) : top;

  always_comb begin
    ed_go   = G_PEND;
    ed_more = 1'b0;
    ed_lvl  = level_r;
    ed_we   = 1'b0;
    if (level_r == '0) begin
      ed_go = G_DONE;
    end else if (top_dec != '0) begin
      ed_we = 1'b1;
    end else begin
      ed_lvl = lvl_m1;
      if (lvl_m1 == '0) begin
        ed_go = G_DONE;
      end else begin
        ed_more = 1'b1;
      end
    end
  end

  assign acc_sh   = {acc_r[23:0], it.data};
  assign hl_dec   = (hdr_left_r != '0) ? hdr_left_r - 3'd1 : hdr_left_r;
  assign pl_dec   = (pay_r != '0) ? pay_r - 32'd1 : pay_r;
  assign size_inc = (size_r == '1) ? size_r : size_r + 32'd1;

  always_comb begin
    state_nxt    = state_r;
    hdr_left_nxt = hdr_left_r;
    acc_nxt      = acc_r;
    kind_nxt     = kind_r;
    pay_nxt      = pay_r;
    size_nxt     = size_r;
    level_nxt    = level_r;
    drop_nxt     = drop_r;
    eob_hold_nxt = eob_hold_r;
    ov_nxt       = ov_r && !pop;
    osize_nxt    = osize_r;
    ostat_nxt    = ostat_r;
    stk_we       = 1'b0;
    stk_idx      = lvl_m1[IDX_W-1:0];
    stk_wdata    = top_dec;
    go           = G_PEND;
    more         = 1'b0;
    fin          = 1'b0;
    fin_eob      = it.eob;
    use_ed       = 1'b0;
    use_open     = 1'b0;
    open_cnt     = '0;

    if (take && drop_r) begin
      if (it.eob) begin
        drop_nxt = 1'b0;
      end
    end else if (take) begin
      size_nxt = size_inc;
      fin      = 1'b1;
      case (state_r)
        S_HEADER: begin
          acc_nxt      = acc_sh;
          hdr_left_nxt = hl_dec;
          if (hl_dec == '0) begin
            state_nxt = S_TYPE;
            case (kind_r)
              HK_BLOB: begin
                if (acc_sh == '0) begin
                  use_ed = 1'b1;
                end else begin
                  pay_nxt   = acc_sh;
                  state_nxt = S_PAYLOAD;
                end
              end
              HK_MAP: begin
                use_open = 1'b1;
                open_cnt = {acc_sh, 1'b0};
              end
              default: begin
                use_open = 1'b1;
                open_cnt = {1'b0, acc_sh};
              end
            endcase
          end
        end
        S_PAYLOAD: begin
          pay_nxt = pl_dec;
          if (pl_dec == '0) begin
            state_nxt = S_TYPE;
            use_ed    = 1'b1;
          end
        end
        default: begin
          case (it.dec.cls)
            TC_SCALAR: begin
              use_ed = 1'b1;
            end
            TC_PAYLOAD: begin
              if (it.dec.len == '0) begin
                use_ed = 1'b1;
              end else begin
                pay_nxt   = {27'd0, it.dec.len};
                state_nxt = S_PAYLOAD;
              end
            end
            TC_OPEN: begin
              use_open = 1'b1;
              open_cnt = {28'd0, it.dec.len};
            end
            TC_HEADER: begin
              kind_nxt     = it.dec.kind;
              hdr_left_nxt = it.dec.hbytes;
              acc_nxt      = '0;
              state_nxt    = S_HEADER;
            end
            default: begin
              go = G_UNK;
            end
          endcase
        end
      endcase

      if (use_open) begin
        if (open_cnt == '0) begin
          use_ed = 1'b1;
        end else if (level_r == LVL_W'(MAX_DEPTH)) begin
          go = G_DEEP;
        end else begin
          stk_we    = 1'b1;
          stk_idx   = level_r[IDX_W-1:0];
          stk_wdata = open_cnt;
          level_nxt = level_r + LVL_W'(1);
        end
      end
    end else if (step) begin
      use_ed    = 1'b1;
      fin       = 1'b1;
      fin_eob   = eob_hold_r;
      state_nxt = S_TYPE;
    end

    if (use_ed) begin
      go        = ed_go;
      more      = ed_more;
      level_nxt = ed_lvl;
      stk_we    = ed_we;
    end

    if (fin && more) begin
      state_nxt    = S_UNWIND;
      eob_hold_nxt = fin_eob;
    end else if (fin) begin
      case (go)
        G_UNK, G_DEEP: begin
          ov_nxt    = 1'b1;
          osize_nxt = '0;
          ostat_nxt = (go == G_UNK) ? ST_UNKNOWN : ST_DEEP;
        end
        G_DONE: begin
          ov_nxt    = 1'b1;
          osize_nxt = size_nxt;
          ostat_nxt = ST_OK;
          size_nxt  = '0;
        end
        default: begin
          if (fin_eob) begin
            ov_nxt    = 1'b1;
            osize_nxt = '0;
            ostat_nxt = ST_TRUNC;
          end
        end
      endcase
      if (go == G_UNK || go == G_DEEP || fin_eob) begin
        state_nxt    = S_TYPE;
        hdr_left_nxt = '0;
        acc_nxt      = '0;
        kind_nxt     = HK_BLOB;
        pay_nxt      = '0;
        size_nxt     = '0;
        level_nxt    = '0;
        drop_nxt     = (go == G_UNK || go == G_DEEP) && !fin_eob;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_TYPE;
      hdr_left_r <= '0;
      acc_r      <= '0;
      kind_r     <= HK_BLOB;
      pay_r      <= '0;
      size_r     <= '0;
      level_r    <= '0;
      drop_r     <= 1'b0;
      eob_hold_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hdr_left_r <= hdr_left_nxt;
      acc_r      <= acc_nxt;
      kind_r     <= kind_nxt;
      pay_r      <= pay_nxt;
      size_r     <= size_nxt;
      level_r    <= level_nxt;
      drop_r     <= drop_nxt;
      eob_hold_r <= eob_hold_nxt;
      ov_r       <= ov_nxt;
    end
    osize_r <= osize_nxt;
    ostat_r <= ostat_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_r[stk_idx] <= stk_wdata;
    end
  end

  assign empty          = !ov_r;
  assign out_value_size = osize_r;
  assign out_status     = ostat_r;

`ifndef SYNTH
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(MAX_DEPTH))
    else $error("nesting level beyond stack depth");
  a_unwind_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNWIND) |-> (level_r != '0))
    else $error("unwinding with no open container");
  a_drop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (level_r == '0 && state_r == S_TYPE && size_r == '0))
    else $error("dropping with scan state left behind");
  a_err_size: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ostat_r != ST_OK) |-> (osize_r == '0))
    else $error("error item carries a size");
  a_no_take_unwind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNWIND) |-> !deq)
    else $error("byte taken during unwind");
`endif

endmodule

FILE: sv/msgpack_value_size_scanner.sv
// Timing: an accepted byte passes through the input queue and the result register to the
//   out_ ports, after any stack unwind steps that the byte causes.
// Throughput: 1 byte per cycle while the result register is free; a byte that closes containers
//   pauses intake for a stack unwind step for each closed container that still has an open parent.
// The result register is freed by pop in the same cycle, so pop every cycle keeps full rate.
// Reset: rst_n synchronous, active low; clears the queue and scan state,
//   the container stack is left as is and only read once written.
module msgpack_value_size_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_buffer,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_value_size,
  output logic [1:0]  out_status
);
  import mvs_pkg::*;

  fq_head_t head;
  logic     deq;

  mvs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .head             (head),
    .deq              (deq)
  );

  mvs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .deq            (deq),
    .empty          (empty),
    .pop            (pop),
    .out_value_size (out_value_size),
    .out_status     (out_status)
  );

endmodule

FILE: verif/msgpack_value_size_scanner_tb.sv
`timescale 1ns / 1ps

module msgpack_value_size_scanner_tb;
  import mvs_pkg::*;

  localparam int TARGET_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SHOW_LIMIT = 10;

  localparam logic [7:0] MP_UNUSED   = 8'hc1;
  localparam logic [7:0] MP_EXT8     = 8'hc7;
  localparam logic [7:0] MP_EXT16    = 8'hc8;
  localparam logic [7:0] MP_EXT32    = 8'hc9;
  localparam logic [7:0] MP_FIXEXT1  = 8'hd4;
  localparam logic [7:0] MP_FIXEXT2  = 8'hd5;
  localparam logic [7:0] MP_FIXEXT4  = 8'hd6;
  localparam logic [7:0] MP_FIXEXT8  = 8'hd7;
  localparam logic [7:0] MP_FIXEXT16 = 8'hd8;

  localparam logic [7:0] UNKNOWN_CODES [9] = '{MP_UNUSED, MP_EXT8, MP_EXT16, MP_EXT32,
    MP_FIXEXT1, MP_FIXEXT2, MP_FIXEXT4, MP_FIXEXT8, MP_FIXEXT16};
  localparam logic [7:0] NUM_CODES [10] = '{MP_UINT8, MP_INT8, MP_UINT16, MP_INT16,
    MP_FLOAT32, MP_UINT32, MP_INT32, MP_FLOAT64, MP_UINT64, MP_INT64};
  localparam int NUM_LENS [10] = '{1, 1, 2, 2, 4, 4, 4, 8, 8, 8};
  localparam logic [7:0] BLOB_CODES [6] = '{MP_BIN8, MP_STR8, MP_BIN16, MP_STR16,
    MP_BIN32, MP_STR32};
  localparam logic [7:0] COUNT_CODES [4] = '{MP_ARRAY16, MP_ARRAY32, MP_MAP16, MP_MAP32};

  typedef enum logic [1:0] {SCAN_TYPE, SCAN_HEADER, SCAN_PAYLOAD} scan_phase_t;
  typedef enum logic [1:0] {STEP_PENDING, STEP_DONE, STEP_UNKNOWN, STEP_DEEP} step_t;

  typedef struct packed {
    logic [31:0] value_size;
    status_t     status;
  } scan_result_t;

  class size_scoreboard;
    scan_phase_t  phase;
    logic [2:0]   hdr_left;
    logic [31:0]  len_acc;
    hkind_t       kind;
    logic [31:0]  pay_left;
    logic [31:0]  byte_count;
    logic [32:0]  open_counts [MAX_DEPTH];
    int           level;
    bit           dropping;
    scan_result_t sizes_q[$];
    int           errors;
    int           shown;
    int           seen [4];

    function void clear_scan();
      phase = SCAN_TYPE;
      hdr_left = '0;
      len_acc = '0;
      kind = HK_BLOB;
      pay_left = '0;
      byte_count = '0;
      level = 0;
      dropping = 1'b0;
    endfunction

    function void reset_all();
      clear_scan();
      sizes_q.delete();
      errors = 0;
      shown = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function int pending();
      return sizes_q.size();
    endfunction

    function step_t close_element();
      while (level > 0) begin
        if (open_counts[level-1] != 0) open_counts[level-1] -= 1;
        if (open_counts[level-1] != 0) return STEP_PENDING;
        level--;
      end
      return STEP_DONE;
    endfunction

    function step_t open_container(logic [32:0] n);
      if (n == 0) return close_element();
      if (level >= MAX_DEPTH) return STEP_DEEP;
      open_counts[level] = n;
      level++;
      return STEP_PENDING;
    endfunction

    function step_t start_payload(logic [31:0] n);
      if (n == 0) return close_element();
      pay_left = n;
      phase = SCAN_PAYLOAD;
      return STEP_PENDING;
    endfunction

    function step_t start_header(hkind_t k, logic [2:0] nb);
      kind = k;
      hdr_left = nb;
      len_acc = '0;
      phase = SCAN_HEADER;
      return STEP_PENDING;
    endfunction

    function step_t classify(logic [7:0] b);
      if (b < MP_FIXMAP || b >= MP_NEGFIX || b == MP_NIL || b == MP_FALSE || b == MP_TRUE)
        return close_element();
      if ((b & 8'he0) == MP_FIXSTR) return start_payload({27'd0, b[4:0]});
      if ((b & 8'hf0) == MP_FIXMAP) return open_container({28'd0, b[3:0], 1'b0});
      if ((b & 8'hf0) == MP_FIXARRAY) return open_container({29'd0, b[3:0]});
      case (b)
        MP_UINT8, MP_INT8: return start_payload(32'd1);
        MP_UINT16, MP_INT16: return start_payload(32'd2);
        MP_FLOAT32, MP_UINT32, MP_INT32: return start_payload(32'd4);
        MP_FLOAT64, MP_UINT64, MP_INT64: return start_payload(32'd8);
        MP_BIN8, MP_STR8: return start_header(HK_BLOB, 3'd1);
        MP_BIN16, MP_STR16: return start_header(HK_BLOB, 3'd2);
        MP_BIN32, MP_STR32: return start_header(HK_BLOB, 3'd4);
        MP_ARRAY16: return start_header(HK_ARRAY, 3'd2);
        MP_ARRAY32: return start_header(HK_ARRAY, 3'd4);
        MP_MAP16: return start_header(HK_MAP, 3'd2);
        MP_MAP32: return start_header(HK_MAP, 3'd4);
        default: return STEP_UNKNOWN;
      endcase
    endfunction

    function void add_expected(logic [31:0] sz, status_t st);
      scan_result_t r;
      r.value_size = sz;
      r.status = st;
      sizes_q.push_back(r);
    endfunction

    // Returns 0 for an item dropped after an error.
    function bit note_byte(logic [7:0] b, logic eob);
      step_t go;
      if (dropping) begin
        if (eob) clear_scan();
        return 1'b0;
      end
      go = STEP_PENDING;
      if (byte_count != '1) byte_count++;
      case (phase)
        SCAN_HEADER: begin
          len_acc = {len_acc[23:0], b};
          if (hdr_left != 0) hdr_left--;
          if (hdr_left == 0) begin
            phase = SCAN_TYPE;
            case (kind)
              HK_BLOB: go = start_payload(len_acc);
              HK_MAP: go = open_container({len_acc, 1'b0});
              default: go = open_container({1'b0, len_acc});
            endcase
          end
        end
        SCAN_PAYLOAD: begin
          if (pay_left != 0) pay_left--;
          if (pay_left == 0) begin
            phase = SCAN_TYPE;
            go = close_element();
          end
        end
        default: go = classify(b);
      endcase
      if (go == STEP_UNKNOWN || go == STEP_DEEP) begin
        add_expected('0, (go == STEP_UNKNOWN) ? ST_UNKNOWN : ST_DEEP);
        clear_scan();
        if (!eob) dropping = 1'b1;
      end else if (go == STEP_DONE) begin
        add_expected(byte_count, ST_OK);
        byte_count = '0;
        if (eob) clear_scan();
      end else if (eob) begin
        add_expected('0, ST_TRUNC);
        clear_scan();
      end
      return 1'b1;
    endfunction

    function void check_result(logic [31:0] sz, status_t st);
      scan_result_t want;
      if (sizes_q.size() == 0) begin
        errors++;
        if (shown < SHOW_LIMIT)
          $display("unexpected result: size %0d status %s", sz, st.name());
        shown++;
        return;
      end
      want = sizes_q.pop_front();
      if (want.value_size !== sz || want.status !== st) begin
        errors++;
        if (shown < SHOW_LIMIT)
          $display("mismatch: expected size %0d status %s, got size %0d status %s",
                   want.value_size, want.status.name(), sz, st.name());
        shown++;
      end else begin
        seen[want.status]++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_buffer = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_value_size;
  logic [1:0]  out_status;

  size_scoreboard sizes;
  logic [7:0] pend_bytes[$];
  int burst_left = 0;
  int fed = 0;
  int sent = 0;
  int buffers = 0;
  int cycles = 0;
  int pop_mode = 0;
  int pop_left = 0;

  msgpack_value_size_scanner DUT (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data_byte(in_data_byte),
    .in_end_of_buffer(in_end_of_buffer),
    .empty(empty),
    .pop(pop),
    .out_value_size(out_value_size),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("msgpack_value_size_scanner_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sizes.check_result(out_value_size, status_t'(out_status));
      if (pop_left == 0) begin
        pop_mode = $urandom_range(0, 3);
        pop_left = (pop_mode == 3) ? $urandom_range(5, 30) : $urandom_range(10, 80);
      end
      pop_left--;
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= 1'b0;
      endcase
    end
  end

  task automatic send_byte(logic [7:0] b, logic eob);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (full) @(posedge clk);
    if (sizes.note_byte(b, eob)) fed++;
    sent++;
    burst_left--;
  endtask

  task automatic send_buffer();
    foreach (pend_bytes[i]) send_byte(pend_bytes[i], i == pend_bytes.size() - 1);
    buffers++;
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (sizes.pending() != 0);
  endtask

  function automatic void put_random(int n);
    repeat (n) pend_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_len(logic [31:0] n, int nb);
    for (int i = nb - 1; i >= 0; i--) pend_bytes.push_back(n[8*i +: 8]);
  endfunction

  function automatic void append_value(int depth);
    int pick;
    int idx;
    int n;
    int nb;
    int k;
    pick = (depth >= 4) ? $urandom_range(0, 3) : $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 3))
          0: pend_bytes.push_back(8'($urandom_range(0, 127)));
          1: pend_bytes.push_back(8'($urandom_range(224, 255)));
          2: pend_bytes.push_back(MP_NIL);
          default: pend_bytes.push_back($urandom_range(0, 1) ? MP_TRUE : MP_FALSE);
        endcase
      end
      1: begin
        idx = $urandom_range(0, 9);
        pend_bytes.push_back(NUM_CODES[idx]);
        put_random(NUM_LENS[idx]);
      end
      2: begin
        n = $urandom_range(0, 31);
        pend_bytes.push_back(MP_FIXSTR | 8'(n));
        put_random(n);
      end
      3: begin
        idx = $urandom_range(0, 5);
        nb = 1 << (idx / 2);
        n = (nb > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(200, 300)
                                                  : $urandom_range(0, 24);
        pend_bytes.push_back(BLOB_CODES[idx]);
        put_len(n, nb);
        put_random(n);
      end
      4, 5: begin
        if (depth == 0 && $urandom_range(0, 7) == 0) begin
          n = $urandom_range(4, 15);
          pend_bytes.push_back(MP_FIXARRAY | 8'(n));
          repeat (n) append_value(4);
        end else begin
          n = $urandom_range(0, 3);
          pend_bytes.push_back(MP_FIXARRAY | 8'(n));
          repeat (n) append_value(depth + 1);
        end
      end
      6: begin
        if (depth == 0 && $urandom_range(0, 7) == 0) begin
          n = $urandom_range(3, 15);
          pend_bytes.push_back(MP_FIXMAP | 8'(n));
          repeat (2 * n) append_value(4);
        end else begin
          n = $urandom_range(0, 2);
          pend_bytes.push_back(MP_FIXMAP | 8'(n));
          repeat (2 * n) append_value(depth + 1);
        end
      end
      7, 8: begin
        idx = $urandom_range(0, 3);
        nb = (idx % 2 == 1) ? 4 : 2;
        n = $urandom_range(0, 3);
        pend_bytes.push_back(COUNT_CODES[idx]);
        put_len(n, nb);
        repeat ((idx >= 2) ? 2 * n : n) append_value(depth + 1);
      end
      default: begin
        k = $urandom_range(1, MAX_DEPTH - depth);
        repeat (k) pend_bytes.push_back(MP_FIXARRAY | 8'd1);
        append_value(depth + k);
      end
    endcase
  endfunction

  task automatic random_buffer();
    int cut;
    pend_bytes.delete();
    repeat ($urandom_range(1, 3)) append_value(0);
    case ($urandom_range(0, 9))
      0: begin
        if (pend_bytes.size() > 1) begin
          cut = $urandom_range(1, pend_bytes.size() - 1);
          while (pend_bytes.size() > cut) void'(pend_bytes.pop_back());
        end
      end
      1: pend_bytes[$urandom_range(0, pend_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      2: begin
        pend_bytes.push_back(UNKNOWN_CODES[$urandom_range(0, 8)]);
        put_random($urandom_range(0, 4));
      end
      3: begin
        repeat (MAX_DEPTH + 1) pend_bytes.push_back(MP_FIXARRAY | 8'($urandom_range(1, 15)));
        put_random($urandom_range(0, 3));
      end
      4: begin
        pend_bytes.delete();
        put_random($urandom_range(1, 8));
      end
      default: ;
    endcase
    send_buffer();
  endtask

  initial begin
    sizes = new();
    sizes.reset_all();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pend_bytes = '{8'h00, 8'hff};
    send_buffer();
    pend_bytes = '{MP_FIXMAP};
    send_buffer();
    pend_bytes = '{MP_UNUSED, 8'h55};
    send_buffer();
    pend_bytes.delete();
    repeat (MAX_DEPTH + 1) pend_bytes.push_back(MP_FIXARRAY | 8'd1);
    send_buffer();
    pend_bytes = '{MP_STR32, 8'hff, 8'hff, 8'hff, 8'hff};
    send_buffer();

    while (fed < TARGET_ITEMS) begin
      random_buffer();
      if (buffers == 60) drain();
    end

    push <= 1'b0;
    while (sizes.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("%0d bytes in %0d buffers (%0d scanned, rest dropped after errors)",
             sent, buffers, fed);
    $display("results: %0d ok, %0d unknown type, %0d truncated, %0d too deep",
             sizes.seen[ST_OK], sizes.seen[ST_UNKNOWN], sizes.seen[ST_TRUNC],
             sizes.seen[ST_DEEP]);
    if (sizes.errors == 0 && sizes.pending() == 0) begin
      $display("msgpack_value_size_scanner_tb: done, clean");
    end else begin
      $display("%0d mismatches", sizes.errors);
      $display("msgpack_value_size_scanner_tb: done, errors");
    end
    $finish;
  end

endmodule
